// ===== design/skhr_pkg.sv =====
// ----------------------------------------------------------------------------
// skhr_pkg
// Shared types, register indexes and saturating helpers for the hedge ratio
// Kalman filter.
// ----------------------------------------------------------------------------
package skhr_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;

  typedef enum logic [2:0] {
    CFG_PROCESS_NOISE   = 3'd0,
    CFG_MEAS_NOISE      = 3'd1,
    CFG_PRIOR_BETA_VLD  = 3'd2,
    CFG_PRIOR_BETA      = 3'd3,
    CFG_PRIOR_VAR_VLD   = 3'd4,
    CFG_PRIOR_VAR       = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED,
    ST_PH,
    ST_XB,
    ST_PHB,
    ST_K,
    ST_KI,
    ST_KB,
    ST_PN,
    ST_HB,
    ST_OUT
  } state_e;

  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic signed [63:0] from_mag(input logic [63:0] m, input logic neg);
    logic signed [63:0] r;
    if (neg) begin
      if (m[63]) r = S64_MIN;
      else r = -$signed(m);
    end else begin
      if (m[63]) r = S64_MAX;
      else r = $signed(m);
    end
    return r;
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    logic signed [63:0] r;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) r = s[64] ? S64_MIN : S64_MAX;
    else r = s[63:0];
    return r;
  endfunction

  function automatic logic signed [63:0] sat_sub64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    logic signed [63:0] r;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) r = s[64] ? S64_MIN : S64_MAX;
    else r = s[63:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -64'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== design/skhr_mul.sv =====
// ----------------------------------------------------------------------------
// skhr_mul
// Bit-serial signed fixed point multiplier: one multiplier bit per cycle,
// then round to nearest (ties away from zero) and saturate to 64 bits.
// ----------------------------------------------------------------------------
module skhr_mul
  import skhr_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] b_i,
  output logic               done_o,
  output logic signed [63:0] res_o
);

  logic        run_q;
  logic [6:0]  cnt_q;
  logic        neg_q;
  logic [63:0] ma_q, mb_q;
  logic [127:0] acc_q;
  logic        done_q;
  logic signed [63:0] res_q;

  logic [64:0]  sum;
  logic [128:0] rnd;
  logic [63:0]  m;

  assign sum = {1'b0, acc_q[127:64]} + {1'b0, (mb_q[0] ? ma_q : 64'd0)};
  assign rnd = {1'b0, acc_q} + (129'd1 << (FRAC_BITS - 1));
  assign m   = (|rnd[128:64+FRAC_BITS]) ? {64{1'b1}} : rnd[63+FRAC_BITS:FRAC_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        if (cnt_q == 7'd64) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q  <= mag64(a_i);
      mb_q  <= mag64(b_i);
      neg_q <= a_i[63] ^ b_i[63];
      acc_q <= '0;
    end else if (run_q) begin
      if (cnt_q == 7'd64) begin
        res_q <= from_mag(m, neg_q);
      end else begin
        acc_q <= {sum, acc_q[63:1]};
        mb_q  <= {1'b0, mb_q[63:1]};
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== design/skhr_div.sv =====
// ----------------------------------------------------------------------------
// skhr_div
// Bit-serial restoring divider for fixed point: one quotient bit per cycle,
// truncates toward zero and saturates to 64 bits.
// ----------------------------------------------------------------------------
module skhr_div
  import skhr_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] n_i,
  input  logic signed [63:0] d_i,
  output logic               done_o,
  output logic signed [63:0] res_o
);

  localparam int unsigned DW = 64 + FRAC_BITS;
  localparam int unsigned CW = $clog2(DW);

  logic          run_q, fin_q, done_q;
  logic [CW-1:0] idx_q;
  logic          neg_q, over_q;
  logic [63:0]   dm_q, r_q, q_q;
  logic [DW-1:0] dvd_q;
  logic signed [63:0] res_q;

  logic [64:0] rs;
  logic        qbit;

  assign rs   = {r_q, dvd_q[DW-1]};
  assign qbit = rs >= {1'b0, dm_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        fin_q <= 1'b0;
        idx_q <= CW'(DW - 1);
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end else if (run_q) begin
        if (idx_q == '0) begin
          run_q <= 1'b0;
          fin_q <= 1'b1;
        end else begin
          idx_q <= idx_q - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dm_q   <= mag64(d_i);
      dvd_q  <= {mag64(n_i), {FRAC_BITS{1'b0}}};
      neg_q  <= n_i[63] ^ d_i[63];
      r_q    <= '0;
      q_q    <= '0;
      over_q <= 1'b0;
    end else if (fin_q) begin
      res_q <= from_mag(over_q ? {64{1'b1}} : q_q, neg_q);
    end else if (run_q) begin
      r_q    <= qbit ? 64'(rs - {1'b0, dm_q}) : rs[63:0];
      q_q    <= {q_q[62:0], qbit};
      over_q <= over_q | (qbit & (32'(idx_q) >= 32'd64));
      dvd_q  <= {dvd_q[DW-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== design/scalar_kalman_hedge_ratio.sv =====
// ----------------------------------------------------------------------------
// scalar_kalman_hedge_ratio
// Tracks the hedge ratio between two prices with a scalar Kalman filter.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. A beat with price_b of zero skips the
// sequencer and goes straight to the output. Any other beat runs a sequencer
// over a shared bit-serial multiplier and a bit-serial divider: seven
// products and one quotient (skipped when the innovation variance is not
// positive), plus one more quotient when the filter must seed.
// A new beat is taken while the previous result waits on the output.
module scalar_kalman_hedge_ratio
  import skhr_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // price_a[31:0], price_b[63:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata   // hedge_ratio, spread, variance[94:64], ready_res
);

  localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

  logic [30:0]        pnoise_q, mnoise_q, pvar_q;
  logic               pbv_q, pvv_q;
  logic signed [31:0] pbeta_q;
  logic signed [31:0] beta_q;
  logic [30:0]        var_q;
  logic               learned_q;

  state_e state_q, state_d;
  logic   busy_q, busy_d;
  logic   mul_start, div_start;
  logic signed [63:0] mul_a, mul_b, div_n, div_d;
  logic   mul_done, div_done;
  logic signed [63:0] mul_res, div_res;

  logic signed [31:0] a_q, b_q;
  logic signed [63:0] x_q, pp_q, ph_q, innov_q, s_q, k_q, t_q;
  logic signed [31:0] hr_q;
  logic [30:0]        pn_q;
  logic signed [31:0] res_hr_q, res_sp_q;
  logic [30:0]        res_var_q;
  logic               res_rdy_q;
  logic               out_vld_q;
  logic [95:0]        out_q;

  logic               acc_in, bk, vk;
  logic signed [31:0] in_a, in_b, bcur;
  logic [30:0]        vcur;
  logic signed [63:0] b64, t_pn;
  logic               op_done;

  assign in_a   = s_axis_tdata[31:0];
  assign in_b   = s_axis_tdata[63:32];
  assign acc_in = s_axis_tvalid & s_axis_tready;
  assign bk     = learned_q | pbv_q;
  assign vk     = learned_q | pvv_q;
  assign bcur   = learned_q ? beta_q : pbeta_q;
  assign vcur   = learned_q ? var_q : pvar_q;
  assign b64    = 64'(b_q);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign op_done = (state_q == ST_SEED || state_q == ST_K) ? div_done : mul_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pnoise_q <= 31'd1;
      mnoise_q <= 31'd66;
      pbv_q    <= 1'b0;
      pbeta_q  <= 32'sd65536;
      pvv_q    <= 1'b0;
      pvar_q   <= 31'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PROCESS_NOISE:  pnoise_q <= cfg_data_i[30:0];
        CFG_MEAS_NOISE:     mnoise_q <= cfg_data_i[30:0];
        CFG_PRIOR_BETA_VLD: pbv_q    <= cfg_data_i[0];
        CFG_PRIOR_BETA:     pbeta_q  <= cfg_data_i;
        CFG_PRIOR_VAR_VLD:  pvv_q    <= cfg_data_i[0];
        CFG_PRIOR_VAR:      pvar_q   <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d   = state_q;
    busy_d    = busy_q;
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = pp_q;
    mul_b     = b64;
    div_n     = 64'(a_q);
    div_d     = b64;
    unique case (state_q)
      ST_SEED: begin div_n = 64'(a_q); div_d = b64; end
      ST_PH:   begin mul_a = pp_q; mul_b = b64; end
      ST_XB:   begin mul_a = x_q;  mul_b = b64; end
      ST_PHB:  begin mul_a = ph_q; mul_b = b64; end
      ST_K:    begin div_n = ph_q; div_d = s_q; end
      ST_KI:   begin mul_a = k_q;  mul_b = innov_q; end
      ST_KB:   begin mul_a = k_q;  mul_b = b64; end
      ST_PN:   begin mul_a = t_q;  mul_b = pp_q; end
      ST_HB:   begin mul_a = 64'(hr_q); mul_b = b64; end
      default: ;
    endcase
    unique case (state_q)
      ST_IDLE: begin
        if (acc_in) begin
          if (in_b == '0) state_d = ST_OUT;
          else if (!(bk && vk)) state_d = ST_SEED;
          else state_d = ST_PH;
        end
      end
      ST_OUT: begin
        if (!out_vld_q || m_axis_tready) state_d = ST_IDLE;
      end
      default: begin
        if (!busy_q) begin
          busy_d = 1'b1;
          if (state_q == ST_SEED || state_q == ST_K) div_start = 1'b1;
          else mul_start = 1'b1;
        end else if (op_done) begin
          busy_d = 1'b0;
          unique case (state_q)
            ST_SEED: state_d = ST_PH;
            ST_PH:   state_d = ST_XB;
            ST_XB:   state_d = ST_PHB;
            ST_PHB:  state_d = (sat_add64(mul_res, 64'(mnoise_q)) > 0) ? ST_K : ST_KI;
            ST_K:    state_d = ST_KI;
            ST_KI:   state_d = ST_KB;
            ST_KB:   state_d = ST_PN;
            ST_PN:   state_d = ST_HB;
            default: state_d = ST_OUT;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      busy_q    <= 1'b0;
      learned_q <= 1'b0;
      beta_q    <= '0;
      var_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
      if (state_q == ST_HB && busy_q && mul_done) begin
        beta_q    <= hr_q;
        var_q     <= pn_q;
        learned_q <= 1'b1;
      end
      if (state_q == ST_OUT && (!out_vld_q || m_axis_tready)) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
    end
  end

  always_comb begin
    t_pn = mul_res;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && acc_in) begin
      a_q       <= in_a;
      b_q       <= in_b;
      x_q       <= 64'(bcur);
      pp_q      <= 64'(vcur) + 64'(pnoise_q);
      k_q       <= '0;
      res_hr_q  <= bk ? bcur : ONE[31:0];
      res_sp_q  <= in_a;
      res_var_q <= vk ? vcur : ONE[30:0];
      res_rdy_q <= bk & vk;
    end
    if (busy_q && op_done) begin
      unique case (state_q)
        ST_SEED: begin
          x_q  <= 64'(sat32(div_res));
          pp_q <= ONE + 64'(pnoise_q);
        end
        ST_PH:  ph_q    <= mul_res;
        ST_XB:  innov_q <= sat_sub64(64'(a_q), mul_res);
        ST_PHB: s_q     <= sat_add64(mul_res, 64'(mnoise_q));
        ST_K:   k_q     <= div_res;
        ST_KI:  hr_q    <= sat32(sat_add64(x_q, mul_res));
        ST_KB:  t_q     <= sat_sub64(ONE, mul_res);
        ST_PN: begin
          if (t_pn < 0) pn_q <= '0;
          else if (t_pn > 64'sh7FFF_FFFF) pn_q <= 31'h7FFF_FFFF;
          else pn_q <= t_pn[30:0];
        end
        ST_HB: begin
          res_hr_q  <= hr_q;
          res_sp_q  <= sat32(sat_sub64(64'(a_q), mul_res));
          res_var_q <= pn_q;
          res_rdy_q <= 1'b1;
        end
        default: ;
      endcase
    end
    if (state_q == ST_OUT && (!out_vld_q || m_axis_tready)) begin
      out_q <= {res_rdy_q, res_var_q, res_sp_q, res_hr_q};
    end
  end

  skhr_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  skhr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .n_i     (div_n),
    .d_i     (div_d),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule
